[rtl/gce_pkg.sv]
// ----------------------------------------------------------------------------
// gce_pkg
// Shared constants, latencies, types and helper functions of the Gumbel
// copula evaluator.
// ----------------------------------------------------------------------------
package gce_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int THETA_FRAC_BITS = 16;
    localparam int REG_W           = 23;
    localparam int VAL_W           = FRAC_BITS + 1;

    localparam logic [VAL_W-1:0] ONE_FB    = VAL_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] THETA_ONE = REG_W'(1) << THETA_FRAC_BITS;
    localparam logic [REG_W-1:0] THETA_RST = REG_W'(65536);
    localparam logic [REG_W-1:0] DELTA_RST = REG_W'(167772);

    localparam logic REG_THETA = 1'b0;
    localparam logic REG_DELTA = 1'b1;

    // unit latencies in enabled cycles
    localparam int LOG_LAT = 33;
    localparam int EXP_LAT = 34;
    localparam int DIV_LAT = 34;

    // copula pipeline timing
    localparam int COP_T_LMAX = 2 * LOG_LAT + 2;
    localparam int LMAX_DLY   = 2 + EXP_LAT + 1 + LOG_LAT + DIV_LAT;
    localparam int COP_LAT    = COP_T_LMAX + LMAX_DLY + 1 + EXP_LAT + 1 + EXP_LAT + 1;

    typedef struct packed {
        logic             hit;
        logic [32:0]      val;
    } t_cspec;

    typedef struct packed {
        logic             cmd;
        logic             inv;
        logic [VAL_W-1:0] den;
    } t_sb;

    typedef struct packed {
        logic             cmd;
        logic             inv;
        logic             zden;
        logic             sat;
        logic [VAL_W-1:0] val0;
        logic [VAL_W-1:0] den;
    } t_fin;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-n) in Q1.31, each a root of the one before
    function automatic logic [31:0] root_at(input int n);
        logic [63:0] r;
        r = 64'h1_0000_0000;
        for (int k = 1; k <= n; k++) begin
            r = isqrt64(r << 31);
        end
        return r[31:0];
    endfunction

    // 32 fraction bits to FRAC_BITS, round half up, saturate at one
    function automatic logic [VAL_W-1:0] to_fb(input logic [32:0] c);
        logic [33:0] r;
        r = (34'(c) + (34'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        return (r > 34'(ONE_FB)) ? ONE_FB : VAL_W'(r);
    endfunction

endpackage

[rtl/gce_log2.sv]
// ----------------------------------------------------------------------------
// gce_log2
// Pipelined log2: normalise, then one squaring step per stage for each of
// the 32 fraction bits.
// ----------------------------------------------------------------------------
module gce_log2 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [37:0] i_x,
    output logic [5:0]  o_p,
    output logic [31:0] o_frac
);
    import gce_pkg::*;

    logic [31:0] r_y  [0:32];
    logic [5:0]  r_p  [0:32];
    logic [31:0] r_fr [0:32];
    logic [5:0]  p_c;
    logic [31:0] y_c;

    always_comb begin
        p_c = '0;
        for (int k = 0; k < 38; k++) begin
            if (i_x[k]) p_c = 6'(k);
        end
        if (p_c >= 6'd31) begin
            y_c = 32'(i_x >> (p_c - 6'd31));
        end else begin
            y_c = 32'(i_x << (6'd31 - p_c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]  <= y_c;
            r_p[0]  <= p_c;
            r_fr[0] <= '0;
        end
    end

    for (genvar g = 1; g <= 32; g++) begin : g_sq
        logic [63:0] sq;
        assign sq = 64'(r_y[g-1]) * 64'(r_y[g-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[g] <= r_p[g-1];
                if (sq[63]) begin
                    r_y[g]  <= sq[63:32];
                    r_fr[g] <= {r_fr[g-1][30:0], 1'b1};
                end else begin
                    r_y[g]  <= sq[62:31];
                    r_fr[g] <= {r_fr[g-1][30:0], 1'b0};
                end
            end
        end
    end

    assign o_p    = r_p[32];
    assign o_frac = r_fr[32];

endmodule

[rtl/gce_exp2.sv]
// ----------------------------------------------------------------------------
// gce_exp2
// Pipelined 2^x: one conditional root multiply per fraction bit, then the
// integer part as a saturating shift.
// ----------------------------------------------------------------------------
module gce_exp2 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [41:0] i_l,
    output logic [62:0]        o_y
);
    import gce_pkg::*;

    logic signed [9:0] r_n [0:32];
    logic [31:0]       r_f [0:32];
    logic [31:0]       r_a [0:32];
    logic [62:0]       r_y;
    logic signed [10:0] s_c;
    logic [6:0]        shr_c;
    logic [62:0]       y_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_l[41:32];
            r_f[0] <= i_l[31:0];
            r_a[0] <= 32'h8000_0000;
        end
    end

    for (genvar g = 1; g <= 32; g++) begin : g_mul
        localparam logic [31:0] ROOT_G = root_at(g);
        logic [63:0] pr;
        assign pr = 64'(r_a[g-1]) * 64'(ROOT_G);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g] <= r_n[g-1];
                r_f[g] <= r_f[g-1];
                r_a[g] <= r_f[g-1][32-g] ? pr[62:31] : r_a[g-1];
            end
        end
    end

    always_comb begin
        s_c   = 11'(r_n[32]) + 11'sd1;
        shr_c = 7'(-s_c);
        if (r_n[32] > 10'sd100) begin
            y_c = 63'(1) << 62;
        end else if (r_n[32] < -10'sd100) begin
            y_c = '0;
        end else if (s_c >= 11'sd0) begin
            y_c = (s_c > 11'sd30) ? (63'(1) << 62) : (63'(r_a[32]) << s_c[4:0]);
        end else begin
            y_c = (shr_c >= 7'd64) ? '0 : (63'(r_a[32]) >> shr_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_y <= y_c;
    end

    assign o_y = r_y;

endmodule

[rtl/gce_div.sv]
// ----------------------------------------------------------------------------
// gce_div
// Pipelined restoring divider, one quotient bit per stage, 33 bits of
// quotient and the final remainder.
// ----------------------------------------------------------------------------
module gce_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [48:0] i_num,
    input  logic [24:0] i_den,
    output logic [32:0] o_q,
    output logic [24:0] o_rem
);
    import gce_pkg::*;

    logic [24:0] r_r  [0:33];
    logic [32:0] r_lo [0:33];
    logic [32:0] r_q  [0:33];
    logic [24:0] r_dv [0:33];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]  <= 25'(i_num[48:33]);
            r_lo[0] <= i_num[32:0];
            r_q[0]  <= '0;
            r_dv[0] <= i_den;
        end
    end

    for (genvar g = 1; g <= 33; g++) begin : g_step
        logic [25:0] trial;
        assign trial = {r_r[g-1], r_lo[g-1][32]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[g] <= r_lo[g-1] << 1;
                r_dv[g] <= r_dv[g-1];
                if (trial >= {1'b0, r_dv[g-1]}) begin
                    r_r[g] <= 25'(trial - {1'b0, r_dv[g-1]});
                    r_q[g] <= {r_q[g-1][31:0], 1'b1};
                end else begin
                    r_r[g] <= trial[24:0];
                    r_q[g] <= {r_q[g-1][31:0], 1'b0};
                end
            end
        end
    end

    assign o_q   = r_q[33];
    assign o_rem = r_r[33];

endmodule

[rtl/gce_cop.sv]
// ----------------------------------------------------------------------------
// gce_cop
// One Gumbel copula lane: C(u,v) with 32 fraction bits, fully pipelined,
// edge values bypassed around the log/exp chain.
// ----------------------------------------------------------------------------
module gce_cop (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [gce_pkg::VAL_W-1:0]    i_u,
    input  logic [gce_pkg::VAL_W-1:0]    i_v,
    input  logic [gce_pkg::REG_W-1:0]    i_t,
    output logic [32:0]                  o_c
);
    import gce_pkg::*;

    localparam logic [33:0] Q32   = 34'h1_0000_0000;
    localparam logic [45:0] TCLMP = 46'(64) << 32;
    localparam logic [62:0] SCLMP = 63'(1) << 40;

    t_cspec            spec_c;
    t_cspec            r_spec [0:COP_LAT-2];
    logic [5:0]        pu, pv, pa, pb, pg;
    logic [31:0]       fu, fv, fa, fb, fg;
    logic [37:0]       r_a, r_b;
    logic signed [38:0] la_c, lb_c, lmax_c, lmin_c;
    logic signed [38:0] r_lmax;
    logic signed [38:0] r_lmd [0:LMAX_DLY-1];
    logic [38:0]       r_dm;
    logic [61:0]       mul_c;
    logic [45:0]       r_pr;
    logic signed [41:0] r_el, r_sarg, r_nl;
    logic [62:0]       x1, s2, x3;
    logic [33:0]       r_xq;
    logic [32:0]       h;
    logic [24:0]       unused_rem;
    logic [32:0]       r_c;

    always_comb begin
        spec_c = '{hit: 1'b0, val: '0};
        if (i_u == '0 || i_v == '0) begin
            spec_c.hit = 1'b1;
        end else if (i_u >= ONE_FB) begin
            spec_c.hit = 1'b1;
            spec_c.val = 33'(i_v) << (32 - FRAC_BITS);
        end else if (i_v >= ONE_FB) begin
            spec_c.hit = 1'b1;
            spec_c.val = 33'(i_u) << (32 - FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec[0] <= spec_c;
            for (int k = 1; k < COP_LAT - 1; k++) r_spec[k] <= r_spec[k-1];
        end
    end

    // -log2 of the marginals
    gce_log2 u_log_u (.i_clk, .i_en, .i_x(38'(i_u)), .o_p(pu), .o_frac(fu));
    gce_log2 u_log_v (.i_clk, .i_en, .i_x(38'(i_v)), .o_p(pv), .o_frac(fv));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= {6'(FRAC_BITS) - pu, 32'h0} - {6'h0, fu};
            r_b <= {6'(FRAC_BITS) - pv, 32'h0} - {6'h0, fv};
        end
    end

    gce_log2 u_log_a (.i_clk, .i_en, .i_x(r_a), .o_p(pa), .o_frac(fa));
    gce_log2 u_log_b (.i_clk, .i_en, .i_x(r_b), .o_p(pb), .o_frac(fb));

    always_comb begin
        la_c   = {7'({1'b0, pa}) - 7'd32, fa};
        lb_c   = {7'({1'b0, pb}) - 7'd32, fb};
        lmax_c = (la_c > lb_c) ? la_c : lb_c;
        lmin_c = (la_c > lb_c) ? lb_c : la_c;
        mul_c  = 62'(r_dm) * 62'(i_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lmax <= lmax_c;
            r_dm   <= 39'(lmax_c - lmin_c);
            r_pr   <= mul_c[61:16];
            r_el   <= -42'((r_pr > TCLMP) ? TCLMP : r_pr);
            r_lmd[0] <= r_lmax;
            for (int k = 1; k < LMAX_DLY; k++) r_lmd[k] <= r_lmd[k-1];
        end
    end

    gce_exp2 u_exp_t (.i_clk, .i_en, .i_l(r_el), .o_y(x1));

    always_ff @(posedge i_clk) begin
        if (i_en) r_xq <= Q32 + ((x1 > 63'(Q32)) ? Q32 : 34'(x1));
    end

    gce_log2 u_log_g (.i_clk, .i_en, .i_x(38'(r_xq)), .o_p(pg), .o_frac(fg));

    // log2(1+x) lies in [0,1], so the integer part is bit 0 of the position
    gce_div u_div (
        .i_clk, .i_en,
        .i_num ({pg[0], fg, 16'h0}),
        .i_den (25'(i_t)),
        .o_q   (h),
        .o_rem (unused_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) r_sarg <= 42'(r_lmd[LMAX_DLY-1]) + 42'({1'b0, h});
    end

    gce_exp2 u_exp_s (.i_clk, .i_en, .i_l(r_sarg), .o_y(s2));

    always_ff @(posedge i_clk) begin
        if (i_en) r_nl <= -42'((s2 > SCLMP) ? SCLMP : s2);
    end

    gce_exp2 u_exp_c (.i_clk, .i_en, .i_l(r_nl), .o_y(x3));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_spec[COP_LAT-2].hit) begin
                r_c <= r_spec[COP_LAT-2].val;
            end else begin
                r_c <= (x3 > 63'(Q32)) ? 33'(Q32) : 33'(x3);
            end
        end
    end

    assign o_c = r_c;

endmodule

[rtl/gumbel_copula_evaluator.sv]
// ----------------------------------------------------------------------------
// gumbel_copula_evaluator
// Gumbel copula value and conditional probability, streaming, one item per
// cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls; returns one result per
// item, in order, via the chain in each copula lane: three pipelined log2
// units and three exp2 units of one stage per fraction bit, and a divider of
// one stage per quotient bit, then a second divider for the conditional
// ratio. Two copula lanes run side by side, so the conditional costs no more
// than the joint value. A stall at the output freezes the whole pipeline. The
// user must write theta and delta only while idle; the block does not check.
module gumbel_copula_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // u[24:0], v[49:25], zero pad
    input  logic        i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // value[24:0], zero pad
    output logic        o_m_axis_tuser,   // invalid
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [22:0] i_cfg_data
);
    import gce_pkg::*;

    logic [REG_W-1:0] r_theta, r_delta, t_c;
    logic             en;

    logic [VAL_W-1:0] u_c, v_c;
    logic [25:0]      d_c, d15_c, v26, vp_c, vm_c;
    logic             inv_c;

    logic             r_f_vld;
    logic [VAL_W-1:0] r_f_u, r_f_va, r_f_vb;
    t_sb              r_f_sb;

    logic             r_sb_vld [0:COP_LAT-1];
    t_sb              r_sb     [0:COP_LAT-1];

    logic [32:0]      c1, c0;
    logic [VAL_W-1:0] num_c;
    logic             r_n_vld;
    logic [VAL_W-1:0] r_n_num;
    t_fin             r_n_fin;

    logic             r_d_vld [0:DIV_LAT-1];
    t_fin             r_d_fin [0:DIV_LAT-1];
    logic [32:0]      q;
    logic [24:0]      rem;
    logic [32:0]      qr_c;
    logic [VAL_W-1:0] val_c;
    t_fin             fin;

    logic             r_out_vld;
    logic [VAL_W-1:0] r_out_val;
    logic             r_out_inv;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign t_c             = (r_theta < THETA_ONE) ? THETA_ONE : r_theta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= THETA_RST;
            r_delta <= DELTA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THETA: r_theta <= i_cfg_data;
                REG_DELTA: r_delta <= i_cfg_data;
                default:   r_theta <= r_theta;
            endcase
        end
    end

    // difference points around v
    always_comb begin
        u_c   = i_s_axis_tdata[24:0];
        v_c   = i_s_axis_tdata[49:25];
        inv_c = (u_c > ONE_FB) || (v_c > ONE_FB);
        d_c   = (r_delta == '0) ? 26'd1 : 26'(r_delta);
        d15_c = d_c + (d_c >> 1);
        v26   = 26'(v_c);
        if (v26 < d_c) begin
            vm_c = v26;
            vp_c = (v26 + d15_c > 26'(ONE_FB)) ? 26'(ONE_FB) : v26 + d15_c;
        end else if (v26 + d_c > 26'(ONE_FB)) begin
            vp_c = v26;
            vm_c = (v26 >= d15_c) ? v26 - d15_c : '0;
        end else begin
            vp_c = v26 + d_c;
            vm_c = v26 - d_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_u      <= u_c;
            r_f_va     <= i_s_axis_tuser ? vp_c[24:0] : v_c;
            r_f_vb     <= vm_c[24:0];
            r_f_sb.cmd <= i_s_axis_tuser;
            r_f_sb.inv <= inv_c;
            r_f_sb.den <= 25'(vp_c - vm_c);
        end
    end

    gce_cop u_cop_a (.i_clk, .i_en(en), .i_u(r_f_u), .i_v(r_f_va), .i_t(t_c), .o_c(c1));
    gce_cop u_cop_b (.i_clk, .i_en(en), .i_u(r_f_u), .i_v(r_f_vb), .i_t(t_c), .o_c(c0));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= r_f_sb;
            for (int k = 1; k < COP_LAT; k++) r_sb[k] <= r_sb[k-1];
        end
    end

    assign num_c = to_fb((c1 > c0) ? c1 - c0 : '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_num       <= num_c;
            r_n_fin.cmd   <= r_sb[COP_LAT-1].cmd;
            r_n_fin.inv   <= r_sb[COP_LAT-1].inv;
            r_n_fin.zden  <= r_sb[COP_LAT-1].den == '0;
            r_n_fin.sat   <= num_c >= r_sb[COP_LAT-1].den;
            r_n_fin.val0  <= to_fb(c1);
            r_n_fin.den   <= r_sb[COP_LAT-1].den;
        end
    end

    gce_div u_div (
        .i_clk, .i_en(en),
        .i_num ({r_n_num, 24'h0}),
        .i_den (r_n_fin.den),
        .o_q   (q),
        .o_rem (rem)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_fin[0] <= r_n_fin;
            for (int k = 1; k < DIV_LAT; k++) r_d_fin[k] <= r_d_fin[k-1];
        end
    end

    always_comb begin
        fin  = r_d_fin[DIV_LAT-1];
        qr_c = ({rem, 1'b0} >= {1'b0, fin.den}) ? q + 33'd1 : q;
        if (fin.inv) begin
            val_c = '0;
        end else if (!fin.cmd) begin
            val_c = fin.val0;
        end else if (fin.zden) begin
            val_c = '0;
        end else if (fin.sat || qr_c > 33'(ONE_FB)) begin
            val_c = ONE_FB;
        end else begin
            val_c = qr_c[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= val_c;
            r_out_inv <= fin.inv;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld   <= 1'b0;
            r_n_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < COP_LAT; k++) r_sb_vld[k] <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) r_d_vld[k] <= 1'b0;
        end else if (en) begin
            r_f_vld     <= i_s_axis_tvalid;
            r_sb_vld[0] <= r_f_vld;
            for (int k = 1; k < COP_LAT; k++) r_sb_vld[k] <= r_sb_vld[k-1];
            r_n_vld     <= r_sb_vld[COP_LAT-1];
            r_d_vld[0]  <= r_n_vld;
            for (int k = 1; k < DIV_LAT; k++) r_d_vld[k] <= r_d_vld[k-1];
            r_out_vld   <= r_d_vld[DIV_LAT-1];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = 32'(r_out_val);
    assign o_m_axis_tuser  = r_out_inv;

`ifndef SYNTH
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[24:0] == '0)
        else $error("invalid result with nonzero value");

    a_val_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[24:0] <= ONE_FB)
        else $error("result above one");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_n_vld) && $stable(r_f_vld))
        else $error("pipeline moved during stall");
`endif

endmodule
